FILE: src/axis_angle_point_rotator_defines.svh
// Assertion macros for the axis-angle point rotator.
`ifndef AXIS_ANGLE_POINT_ROTATOR_DEFINES_SVH
`define AXIS_ANGLE_POINT_ROTATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off while arst_n is low
`define AAPR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on clk, off while arst_n is low
`define AAPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AAPR_ASSERT_IMPL(label, ante, cons, msg)
`define AAPR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: src/aapr_pkg.sv
// Package of the axis-angle point rotator: default widths and register indexes.
`timescale 1ns / 1ps
package aapr_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int COEFF_WIDTH_DEF = 16;

	localparam int CFG_INDEX_WIDTH = 3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_X    = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_Y    = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_Z    = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_THETA = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_THETA = 3'd4;

endpackage

FILE: src/axis_angle_point_rotator.sv
// Axis-angle point rotator: pipelined Rodrigues rotation of 3D points.
//
// Usage:
//  - Configuration: write axis_x/y/z, cos_theta and sin_theta (signed Q1.F,
//    F = COEFF_WIDTH-1) through cfg_we/cfg_index/cfg_wdata while no point is
//    in flight. Writes take effect at once; indexes beyond the list are dropped.
//  - Input: a point transfers at a clock edge with start high and busy low.
//    busy is always low, so one point may transfer on every cycle.
//  - Output: rotated_x/y/z appear for one cycle with done high, driven from the
//    stage 6 output register after the point has passed stages 1 to 5,
//    in input order. The receiver cannot stall the block; it takes each result
//    in the cycle it is shown.
//  - Throughput: one point per cycle. Latency is set by six register stages:
//    coordinate products, dot/cross rounding, axis times dot and cross times
//    sine, projection times one-minus-cosine, final sum and rounding, and
//    saturation into the output register.
//  - Reset: arst_n clears all stage valid bits and loads the identity
//    rotation about z (cos = 2^F-1, sin = 0).
`timescale 1ns / 1ps
`include "axis_angle_point_rotator_defines.svh"

module axis_angle_point_rotator #(
	parameter int COORD_WIDTH = aapr_pkg::COORD_WIDTH_DEF,
	parameter int COEFF_WIDTH = aapr_pkg::COEFF_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [aapr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [COEFF_WIDTH-1:0]                cfg_wdata,
	// point input
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COORD_WIDTH-1:0]         point_x,
	input  logic signed [COORD_WIDTH-1:0]         point_y,
	input  logic signed [COORD_WIDTH-1:0]         point_z,
	// rotated point output
	output logic                                  done,
	output logic signed [COORD_WIDTH-1:0]         rotated_x,
	output logic signed [COORD_WIDTH-1:0]         rotated_y,
	output logic signed [COORD_WIDTH-1:0]         rotated_z
);
	import aapr_pkg::*;

	localparam int F    = COEFF_WIDTH - 1;
	localparam int PW   = COORD_WIDTH + COEFF_WIDTH;  // coefficient times coordinate
	localparam int DSW  = PW + 2;                     // sum of three products
	localparam int DW   = DSW - F;                    // rounded dot product
	localparam int QSW  = PW + 1;                     // difference of two products
	localparam int QW   = QSW - F;                    // rounded cross product
	localparam int TPW  = COEFF_WIDTH + DW;           // axis times dot
	localparam int TW   = TPW - F;                    // rounded projection
	localparam int OW   = COEFF_WIDTH + 2;            // one minus cosine, up to 2^(F+1)
	localparam int SW   = QW + COEFF_WIDTH;           // cross times sine
	localparam int MW   = TW + OW;                    // projection times one minus cosine
	localparam int ACCW = MW + 2;                     // final accumulator
	localparam int RW   = ACCW - F;                   // rounded result before clamp

	localparam logic signed [OW-1:0] ONE_F = {2'b00, 1'b1, {F{1'b0}}};
	localparam logic signed [COEFF_WIDTH-1:0] COEFF_MAX = {1'b0, {F{1'b1}}};
	localparam logic signed [RW-1:0] SAT_HI =
		{{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [RW-1:0] SAT_LO =
		{{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

	// configuration registers
	logic signed [COEFF_WIDTH-1:0] axis_x_q, axis_y_q, axis_z_q;
	logic signed [COEFF_WIDTH-1:0] cos_theta_q, sin_theta_q;

	// lane views
	logic signed [COEFF_WIDTH-1:0] k [3];
	logic signed [COORD_WIDTH-1:0] p [3];
	logic signed [OW-1:0]          omc;
	logic                          in_xfer;

	// pipeline registers
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PW-1:0]          dot_s1 [3];
	logic signed [PW-1:0]          crs_s1 [6];
	logic signed [PW-1:0]          pc_s1  [3];
	logic signed [DW-1:0]          d_s2;
	logic signed [QW-1:0]          q_s2   [3];
	logic signed [PW-1:0]          pc_s2  [3];
	logic signed [TW-1:0]          t_s3   [3];
	logic signed [SW-1:0]          qs_s3  [3];
	logic signed [PW-1:0]          pc_s3  [3];
	logic signed [MW-1:0]          tm_s4  [3];
	logic signed [ACCW-1:0]        base_s4[3];
	logic signed [RW-1:0]          r_s5   [3];
	logic signed [COORD_WIDTH-1:0] out_q  [3];
	logic                          done_q;

	logic signed [DSW-1:0]         dsum;
	logic signed [QSW-1:0]         qsum   [3];
	logic signed [TPW-1:0]         tprod  [3];
	logic signed [ACCW-1:0]        acc    [3];

	assign k[0] = axis_x_q;
	assign k[1] = axis_y_q;
	assign k[2] = axis_z_q;
	assign p[0] = point_x;
	assign p[1] = point_y;
	assign p[2] = point_z;
	assign omc  = ONE_F - OW'(cos_theta_q);

	// every stage advances each cycle, so the input is never held off
	assign busy    = 1'b0;
	assign in_xfer = start && !busy;

	// write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q    <= '0;
			axis_y_q    <= '0;
			axis_z_q    <= COEFF_MAX;
			cos_theta_q <= COEFF_MAX;
			sin_theta_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AXIS_X:    axis_x_q    <= cfg_wdata;
				REG_AXIS_Y:    axis_y_q    <= cfg_wdata;
				REG_AXIS_Z:    axis_z_q    <= cfg_wdata;
				REG_COS_THETA: cos_theta_q <= cfg_wdata;
				REG_SIN_THETA: sin_theta_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_xfer;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	// stage 1: axis-coordinate products and coordinate times cosine
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dot_s1[i] <= k[i] * p[i];
			pc_s1[i]  <= p[i] * cos_theta_q;
		end
		crs_s1[0] <= k[1] * p[2];
		crs_s1[1] <= k[2] * p[1];
		crs_s1[2] <= k[2] * p[0];
		crs_s1[3] <= k[0] * p[2];
		crs_s1[4] <= k[0] * p[1];
		crs_s1[5] <= k[1] * p[0];
	end

	// stage 2: sum and round dot and cross products
	always_comb begin
		dsum = DSW'(dot_s1[0]) + DSW'(dot_s1[1]) + DSW'(dot_s1[2]);
		for (int i = 0; i < 3; i++) begin
			qsum[i] = QSW'(crs_s1[2*i]) - QSW'(crs_s1[2*i+1]);
		end
	end

	always_ff @(posedge clk) begin
		d_s2 <= DW'(dsum >>> F) + DW'(dsum[F-1]);
		for (int i = 0; i < 3; i++) begin
			q_s2[i]  <= QW'(qsum[i] >>> F) + QW'(qsum[i][F-1]);
			pc_s2[i] <= pc_s1[i];
		end
	end

	// stage 3: axis times dot (rounded) and cross times sine
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tprod[i] = k[i] * d_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_s3[i]  <= TW'(tprod[i] >>> F) + TW'(tprod[i][F-1]);
			qs_s3[i] <= q_s2[i] * sin_theta_q;
			pc_s3[i] <= pc_s2[i];
		end
	end

	// stage 4: projection times one minus cosine; combine the other two terms
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			tm_s4[i]   <= t_s3[i] * omc;
			base_s4[i] <= ACCW'(pc_s3[i]) + ACCW'(qs_s3[i]);
		end
	end

	// stage 5: final sum and rounding
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = base_s4[i] + ACCW'(tm_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r_s5[i] <= RW'(acc[i] >>> F) + RW'(acc[i][F-1]);
		end
	end

	// stage 6: clamp to the coordinate range
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (r_s5[i] > SAT_HI) begin
				out_q[i] <= COORD_WIDTH'(SAT_HI);
			end else if (r_s5[i] < SAT_LO) begin
				out_q[i] <= COORD_WIDTH'(SAT_LO);
			end else begin
				out_q[i] <= COORD_WIDTH'(r_s5[i]);
			end
		end
	end

	assign done      = done_q;
	assign rotated_x = out_q[0];
	assign rotated_y = out_q[1];
	assign rotated_z = out_q[2];

	// checks
	`AAPR_ASSERT_IMPL(a_done_latency, done, $past(in_xfer, 6), "result without a transfer six cycles earlier")
	`AAPR_ASSERT_NEXT(a_s1_to_s2, v_s1, v_s2, "stage 1 item lost before stage 2")
	`AAPR_ASSERT_IMPL(a_s4_from_s3, v_s4, $past(v_s3), "stage 4 item with no stage 3 item before it")

endmodule
